FILE: hdl/vdr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the valve dead-reckoning positioner.
// Used by the channel interfaces and by every module of the block.
package vdr_pkg;

  localparam int TARGET_W = 17;
  localparam int TIME_W   = 32;
  localparam int PCT_W    = 7;

  localparam logic [TARGET_W-1:0] Q16_ONE    = 17'd65536;
  localparam logic [TARGET_W-1:0] STEP_RESET = 17'd874;

  localparam int STROKE_S  = 150;
  localparam int MS_PER_S  = 1000;
  localparam int PCT_SCALE = 100;

  localparam logic [TIME_W-1:0] STROKE_MS = TIME_W'(STROKE_S * MS_PER_S);

  localparam int ELAPSED_W = $clog2(STROKE_S * MS_PER_S);
  localparam int SEC_W     = $clog2(STROKE_S + 1);
  localparam int HOME_X_W  = $clog2(PCT_SCALE * STROKE_S);

  localparam int SEC_SHIFT = 32;
  localparam int SEC_MUL_W = 23;
  localparam logic [SEC_MUL_W-1:0] SEC_MUL =
    SEC_MUL_W'(((64'd1 << SEC_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

  localparam int PCT_SHIFT = 32;
  localparam int PCT_MUL_W = 33;
  localparam logic [PCT_MUL_W-1:0] PCT_MUL =
    PCT_MUL_W'(((64'd1 << PCT_SHIFT) + 64'(STROKE_S) - 64'd1) / 64'(STROKE_S));

  localparam int RUN_SCALED_W = 24;

  typedef enum logic [1:0] {
    MODE_STOP,
    MODE_HOME,
    MODE_RUN
  } mode_t;

  typedef struct packed {
    logic                safe_state;
    logic                heating_enabled;
    logic [TARGET_W-1:0] valve_target;
    logic [TIME_W-1:0]   now_ms;
  } vdr_in_t;

  typedef struct packed {
    mode_t               mode;
    logic                home_start;
    logic                home_end;
    logic                finished;
    logic [SEC_W-1:0]    seconds;
    logic [TARGET_W-1:0] target;
  } vdr_job_t;

  typedef struct packed {
    logic             pump_on;
    logic             valve_open_drive;
    logic             valve_close_drive;
    logic [PCT_W-1:0] position_percent;
    logic             homing_done;
  } vdr_result_t;

endpackage

FILE: hdl/vdr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input ticks, results and the step register.
// Depends on vdr_pkg for field widths.
interface vdr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         safe_state;
  logic                         heating_enabled;
  logic [vdr_pkg::TARGET_W-1:0] valve_target;
  logic [vdr_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, safe_state, heating_enabled, valve_target, now_ms,
                  input ready);
  modport sink   (input valid, safe_state, heating_enabled, valve_target, now_ms,
                  output ready);
endinterface

interface vdr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      pump_on;
  logic                      valve_open_drive;
  logic                      valve_close_drive;
  logic [vdr_pkg::PCT_W-1:0] position_percent;
  logic                      homing_done;

  modport source (output valid, pump_on, valve_open_drive, valve_close_drive,
                  position_percent, homing_done, input ready);
  modport sink   (input valid, pump_on, valve_open_drive, valve_close_drive,
                  position_percent, homing_done, output ready);
endinterface

interface vdr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [vdr_pkg::TARGET_W-1:0] stroke_step;

  modport source (output valid, stroke_step, input ready);
  modport sink   (input valid, stroke_step, output ready);
endinterface

FILE: hdl/vdr_homing.sv
`timescale 1ns / 1ps
// First stage: homing timer state, branch decision and elapsed seconds.
// Depends on vdr_pkg.
module vdr_homing (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  vdr_pkg::vdr_in_t  item,
  output vdr_pkg::vdr_job_t job
);
  import vdr_pkg::*;

  logic                           started_r;
  logic                           finished_r;
  logic [TIME_W-1:0]              start_r;
  vdr_job_t                       job_r;
  vdr_job_t                       job_nxt;
  mode_t                          mode;
  logic                           begin_home;
  logic                           done_now;
  logic [TIME_W-1:0]              start_eff;
  logic [TIME_W-1:0]              elapsed;
  logic [ELAPSED_W+SEC_MUL_W-1:0] sec_prod;
  logic [TARGET_W-1:0]            tgt;

  always_comb begin
    if (item.safe_state || !item.heating_enabled) begin
      mode = MODE_STOP;
    end else if (finished_r) begin
      mode = MODE_RUN;
    end else begin
      mode = MODE_HOME;
    end
    begin_home = (mode == MODE_HOME) && !started_r;
    start_eff  = begin_home ? item.now_ms : start_r;
    elapsed    = item.now_ms - start_eff;
    done_now   = (mode == MODE_HOME) && (elapsed >= STROKE_MS);
    sec_prod   = (ELAPSED_W+SEC_MUL_W)'(elapsed[ELAPSED_W-1:0]) *
                 (ELAPSED_W+SEC_MUL_W)'(SEC_MUL);
    tgt        = (item.valve_target > Q16_ONE) ? Q16_ONE : item.valve_target;

    job_nxt.mode       = mode;
    job_nxt.home_start = begin_home;
    job_nxt.home_end   = done_now;
    job_nxt.finished   = finished_r || done_now;
    job_nxt.seconds    = sec_prod[SEC_SHIFT +: SEC_W];
    job_nxt.target     = tgt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      finished_r <= 1'b0;
      start_r    <= '0;
    end else if (adv) begin
      started_r  <= started_r || begin_home;
      finished_r <= finished_r || done_now;
      start_r    <= start_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r <= job_nxt;
    end
  end

  assign job = job_r;

endmodule

FILE: hdl/vdr_drive.sv
`timescale 1ns / 1ps
// Second stage: relay levels, position estimate and reported percent.
// Depends on vdr_pkg; its registers are the block's result register.
module vdr_drive (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  vdr_pkg::vdr_job_t             job,
  input  logic [vdr_pkg::TARGET_W-1:0]  stroke_step,
  output vdr_pkg::vdr_result_t          res
);
  import vdr_pkg::*;

  logic [TARGET_W-1:0]           pos_r;
  logic [TARGET_W-1:0]           pos_nxt;
  logic                          pump_r;
  logic                          pump_nxt;
  logic                          open_r;
  logic                          open_nxt;
  logic                          close_r;
  logic                          close_nxt;
  logic [PCT_W-1:0]              pct_r;
  logic [PCT_W-1:0]              pct_nxt;
  logic                          done_r;
  logic [TARGET_W-1:0]           step;
  logic                          go_up;
  logic                          go_down;
  logic [TARGET_W-1:0]           pos_move;
  logic [RUN_SCALED_W-1:0]       run_scaled;
  logic [HOME_X_W-1:0]           home_x;
  logic [HOME_X_W+PCT_MUL_W-1:0] home_prod;
  logic [PCT_W-1:0]              home_pct;

  always_comb begin
    if (stroke_step == '0) begin
      step = TARGET_W'(1);
    end else if (stroke_step > Q16_ONE) begin
      step = Q16_ONE;
    end else begin
      step = stroke_step;
    end
    go_up   = {1'b0, job.target} > ({1'b0, pos_r} + {1'b0, step});
    go_down = {1'b0, pos_r} > ({1'b0, job.target} + {1'b0, step});
    if (go_up) begin
      pos_move = pos_r + step;
    end else if (go_down) begin
      pos_move = pos_r - step;
    end else begin
      pos_move = job.target;
    end
    run_scaled = RUN_SCALED_W'(pos_move) * RUN_SCALED_W'(PCT_SCALE);

    home_x    = HOME_X_W'(job.seconds) * HOME_X_W'(PCT_SCALE);
    home_prod = (HOME_X_W+PCT_MUL_W)'(home_x) * (HOME_X_W+PCT_MUL_W)'(PCT_MUL);
    home_pct  = job.home_end ? PCT_W'(PCT_SCALE) : home_prod[PCT_SHIFT +: PCT_W];

    pos_nxt   = pos_r;
    pump_nxt  = pump_r;
    open_nxt  = open_r;
    close_nxt = close_r;
    pct_nxt   = pct_r;
    case (job.mode)
      MODE_STOP: begin
        pump_nxt  = 1'b0;
        open_nxt  = 1'b0;
        close_nxt = 1'b0;
      end
      MODE_HOME: begin
        pump_nxt = 1'b0;
        pct_nxt  = home_pct;
        if (job.home_start) begin
          open_nxt  = 1'b1;
          close_nxt = 1'b0;
        end
        if (job.home_end) begin
          open_nxt  = 1'b0;
          close_nxt = 1'b0;
          pos_nxt   = Q16_ONE;
        end
      end
      MODE_RUN: begin
        pump_nxt  = (job.target != '0);
        open_nxt  = go_up;
        close_nxt = go_down && !go_up;
        pos_nxt   = pos_move;
        pct_nxt   = run_scaled[16 +: PCT_W];
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      pump_r  <= 1'b0;
      open_r  <= 1'b0;
      close_r <= 1'b0;
      pct_r   <= '0;
      done_r  <= 1'b0;
    end else if (adv) begin
      pos_r   <= pos_nxt;
      pump_r  <= pump_nxt;
      open_r  <= open_nxt;
      close_r <= close_nxt;
      pct_r   <= pct_nxt;
      done_r  <= job.finished;
    end
  end

  assign res.pump_on           = pump_r;
  assign res.valve_open_drive  = open_r;
  assign res.valve_close_drive = close_r;
  assign res.position_percent  = pct_r;
  assign res.homing_done       = done_r;

endmodule

FILE: hdl/valve_dead_reckoning_positioner_core.sv
`timescale 1ns / 1ps
// Top level of the valve dead-reckoning positioner.
// Depends on vdr_pkg, the channel interfaces, vdr_homing and vdr_drive.
//
// Usage:
// Each item on in_ch is one control tick: safe-state flag, heating enable,
// Q16 valve target and a millisecond timestamp. Each tick yields exactly
// one item on out_ch with the pump and valve relay levels, the reported
// opening in whole percent and the homing-done flag.
// cfg_ch writes the per-tick valve step (Q16 of full stroke); it is always
// ready and should only be written while no tick is in flight.
// The block is a three-register pipeline: input register, homing stage and
// drive stage whose registers form the result register, which is shown on
// out_ch. One tick can be accepted every cycle while out_ch does not stall.
// The timer and homing state advance as a tick leaves the input register;
// relays, position and percent advance as it enters the result register.
// When out_ch stalls, the stages hold in place and in_ch ready drops only
// once every stage is full.
// Reset clears the valid flags and the homing and drive state: homing not started,
// relays off, position and percent zero, valve step 874.
module valve_dead_reckoning_positioner_core (
  input  logic      clk,
  input  logic      rst_n,
  vdr_in_if.sink    in_ch,
  vdr_out_if.source out_ch,
  vdr_cfg_if.sink   cfg_ch
);
  import vdr_pkg::*;

  vdr_in_t             in_r;
  logic                v0_r;
  logic                v1_r;
  logic                ov_r;
  logic [TARGET_W-1:0] step_r;
  logic                adv0;
  logic                adv1;
  logic                adv2;
  vdr_job_t            job;
  vdr_result_t         res;

  assign adv2 = v1_r && (!ov_r || out_ch.ready);
  assign adv1 = v0_r && (!v1_r || adv2);
  assign adv0 = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !v0_r || adv1;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      ov_r   <= 1'b0;
      step_r <= STEP_RESET;
    end else begin
      if (adv0) begin
        v0_r <= 1'b1;
      end else if (adv1) begin
        v0_r <= 1'b0;
      end
      if (adv1) begin
        v1_r <= 1'b1;
      end else if (adv2) begin
        v1_r <= 1'b0;
      end
      if (adv2) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        step_r <= cfg_ch.stroke_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      in_r.safe_state      <= in_ch.safe_state;
      in_r.heating_enabled <= in_ch.heating_enabled;
      in_r.valve_target    <= in_ch.valve_target;
      in_r.now_ms          <= in_ch.now_ms;
    end
  end

  vdr_homing u_homing (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv1),
    .item  (in_r),
    .job   (job)
  );

  vdr_drive u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv2),
    .job         (job),
    .stroke_step (step_r),
    .res         (res)
  );

  assign out_ch.valid             = ov_r;
  assign out_ch.pump_on           = res.pump_on;
  assign out_ch.valve_open_drive  = res.valve_open_drive;
  assign out_ch.valve_close_drive = res.valve_close_drive;
  assign out_ch.position_percent  = res.position_percent;
  assign out_ch.homing_done       = res.homing_done;

endmodule
